// ----- src/integer_to_radix_ascii_defines.svh -----
// Assertion macros for the RTL file that checks its own logic.
`ifndef INTEGER_TO_RADIX_ASCII_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define ITRA_ASSERT_SAME(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("itra assertion failed");

// The condition must hold in the cycle after the trigger.
`define ITRA_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("itra assertion failed");

`endif

// ----- src/itra_pkg.sv -----
package itra_pkg;

    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_AW   = $clog2(VALUE_BITS);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] DIGIT_TEN  = 7'd10;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_SIGN = 5'b00100,
        ST_READ = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (dx <= 7'd9)
        begin
            return dx + CHAR_ZERO;
        end
        return dx - DIGIT_TEN + CHAR_A;
    endfunction

endpackage

// ----- src/itra_value_if.sv -----
interface itra_value_if import itra_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- src/itra_char_if.sv -----
interface itra_char_if import itra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              final_char;

    modport source (output valid, output character, output final_char, input ready);
    modport sink   (input valid, input character, input final_char, output ready);
endinterface

// ----- src/itra_div.sv -----
module itra_div import itra_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [RADIX_W-1:0]    divisor,
    output div_stat_t             stat,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [RADIX_W-1:0]    remainder
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] work_reg, work_next;
    logic [RADIX_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W:0]      partial;
    logic                  fits;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of the work register while quotient bits shift in below.
    assign partial = {rem_reg, work_reg[VALUE_BITS-1]};
    assign fits    = partial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_BITS - 1);
            work_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[VALUE_BITS-2:0], fits};
            rem_next  = fits ? RADIX_W'(partial - {1'b0, divisor}) : partial[RADIX_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

// ----- src/integer_to_radix_ascii.sv -----
// A value is divided by the radix once per digit on the one shared divider; a
// minus sign, when the value is negative, is sent before the digits, and each
// digit is read from the digit memory in ST_READ and sent from ST_OUT. A new value
// is accepted only once the last character of the previous one has been loaded.
// Reset (rst_n low, asynchronous) sets the radix to 10, empties the output
// register and returns the sequencer to idle.
`include "integer_to_radix_ascii_defines.svh"

module integer_to_radix_ascii import itra_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [RADIX_W-1:0] cfg_wdata,
    itra_value_if.sink         number,
    itra_char_if.source        text
);

    state_t                state_reg, state_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic                  neg_reg, neg_next;
    logic [DIGIT_AW-1:0]   wr_idx_reg, wr_idx_next;
    logic [DIGIT_AW-1:0]   idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     out_char_reg, out_char_next;
    logic                  out_final_reg, out_final_next;
    logic [CHAR_W-1:0]     rd_reg;
    logic [CHAR_W-1:0]     digit_mem [VALUE_BITS];
    logic                  wr_en;
    logic                  out_load;
    logic                  out_free;

    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    div_stat_t             div_stat;
    logic [VALUE_BITS-1:0] div_quot;
    logic [RADIX_W-1:0]    div_rem;

    itra_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (radix_reg),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // The negation of the most negative value wraps to itself, which read
    // as unsigned is exactly its magnitude.
    assign in_neg   = number.value[VALUE_BITS-1];
    assign in_mag   = in_neg ? (~number.value + 1'b1) : number.value;
    assign out_free = !out_valid_reg || text.ready;

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_we)
        begin
            if (cfg_wdata < RADIX_MIN)
            begin
                radix_next = RADIX_MIN;
            end
            else if (cfg_wdata > RADIX_MAX)
            begin
                radix_next = RADIX_MAX;
            end
            else
            begin
                radix_next = cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        wr_idx_next    = wr_idx_reg;
        idx_next       = idx_reg;
        div_start      = 1'b0;
        div_dividend   = div_quot;
        wr_en          = 1'b0;
        out_load       = 1'b0;
        out_char_next  = out_char_reg;
        out_final_next = out_final_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (number.valid)
                begin
                    div_start    = 1'b1;
                    div_dividend = in_mag;
                    neg_next     = in_neg;
                    wr_idx_next  = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    // Digits are stored least significant first.
                    wr_en       = 1'b1;
                    wr_idx_next = wr_idx_reg + 1'b1;
                    if (div_quot != '0)
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        idx_next   = wr_idx_reg;
                        state_next = neg_reg ? ST_SIGN : ST_READ;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_final_next = 1'b0;
                    state_next     = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_char_next  = rd_reg;
                    out_final_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (text.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            neg_reg       <= 1'b0;
            wr_idx_reg    <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radix_reg     <= radix_next;
            neg_reg       <= neg_next;
            wr_idx_reg    <= wr_idx_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        out_final_reg <= out_final_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            digit_mem[wr_idx_reg] <= digit_char(div_rem);
        end
        rd_reg <= digit_mem[idx_reg];
    end

    assign number.ready    = (state_reg == ST_IDLE);
    assign text.valid      = out_valid_reg;
    assign text.character  = out_char_reg;
    assign text.final_char = out_final_reg;

    `ITRA_ASSERT_SAME(a_ready_div_idle, number.ready, !div_stat.busy)
    `ITRA_ASSERT_SAME(a_start_div_idle, div_start, !div_stat.busy && !div_stat.done || state_reg == ST_DIV)
    `ITRA_ASSERT_SAME(a_radix_range, 1'b1, radix_reg >= RADIX_MIN && radix_reg <= RADIX_MAX)
    `ITRA_ASSERT_NEXT(a_last_char_idle, state_reg == ST_OUT && out_free && idx_reg == '0, state_reg == ST_IDLE && text.valid && text.final_char)

endmodule
